// ===== hdl/bbps_pkg.sv =====
// Shared types, register codes, fixed-point helpers and the tick program
// for the ball body physics step. No dependencies.
`default_nettype none

package bbps_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRAVITY_X = 3'd0;
    localparam logic [2:0] CFG_GRAVITY_Y = 3'd1;
    localparam logic [2:0] CFG_GRAVITY_Z = 3'd2;
    localparam logic [2:0] CFG_INV_MASS  = 3'd3;
    localparam logic [2:0] CFG_SPAWN_X   = 3'd4;
    localparam logic [2:0] CFG_SPAWN_Y   = 3'd5;
    localparam logic [2:0] CFG_SPAWN_Z   = 3'd6;
    localparam logic [2:0] CFG_TIME_STEP = 3'd7;

    localparam int IN_DATA_W  = 296;
    localparam int OUT_DATA_W = 200;

    // One decoded request as held in the queue.
    typedef struct packed {
        logic           is_tick;
        logic           hit;
        logic [2:0][31:0] force_v;
        logic [2:0][31:0] clip;
        logic [2:0][31:0] normal;
    } t_item;

    // Configuration registers as seen by the back end.
    typedef struct packed {
        logic [2:0][31:0] gravity;
        logic [30:0]      inv_mass;
        logic [2:0][31:0] spawn;
        logic [16:0]      dt;
    } t_cfg;

    // Program step operations.
    typedef enum logic [3:0] {
        OP_RESPAWN, OP_CLIP, OP_MDOT, OP_MADDM, OP_MSUBM, OP_MADDS, OP_MNEGNUM,
        OP_NUMNEG, OP_NUM, OP_DEN, OP_SQRT, OP_DIV, OP_SKIPSLOW, OP_END
    } t_op;

    typedef enum logic [3:0] {
        SRC_P, SRC_V, SRC_F, SRC_ACC, SRC_N, SRC_G, SRC_K, SRC_H, SRC_C,
        SRC_FRIC, SRC_INVM, SRC_DT
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE, DST_ACC, DST_V, DST_P, DST_K, DST_H, DST_C
    } t_dst;

    typedef struct packed {
        t_op        op;
        t_src       a;
        t_src       b;
        t_dst       dst;
        logic [1:0] idx;
    } t_uop;

    // Program addresses of the tick sequence.
    localparam logic [5:0] PC_RESPAWN = 6'd0;
    localparam logic [5:0] PC_CLIP    = 6'd1;
    localparam logic [5:0] PC_GG      = 6'd2;
    localparam logic [5:0] PC_KNUM    = 6'd5;
    localparam logic [5:0] PC_NG      = 6'd6;
    localparam logic [5:0] PC_KDEN    = 6'd9;
    localparam logic [5:0] PC_KDIV    = 6'd10;
    localparam logic [5:0] PC_NK      = 6'd11;
    localparam logic [5:0] PC_NV      = 6'd14;
    localparam logic [5:0] PC_HNUM    = 6'd17;
    localparam logic [5:0] PC_NN      = 6'd18;
    localparam logic [5:0] PC_HSQ     = 6'd21;
    localparam logic [5:0] PC_HDIV    = 6'd22;
    localparam logic [5:0] PC_NH      = 6'd23;
    localparam logic [5:0] PC_VV      = 6'd26;
    localparam logic [5:0] PC_VSQ     = 6'd29;
    localparam logic [5:0] PC_SLOW    = 6'd30;
    localparam logic [5:0] PC_FK      = 6'd31;
    localparam logic [5:0] PC_CDIV    = 6'd32;
    localparam logic [5:0] PC_VC      = 6'd33;
    localparam logic [5:0] PC_INTEG   = 6'd36;
    localparam logic [5:0] PC_VEL     = 6'd39;
    localparam logic [5:0] PC_POS     = 6'd42;

    // Sign-extend a 32-bit word to the 66-bit working width.
    function automatic logic [65:0] sx32(input logic [31:0] x);
        return {{34{x[31]}}, x};
    endfunction

    // Sign-extend a 64-bit word to the 66-bit working width.
    function automatic logic [65:0] sx64(input logic [63:0] x);
        return {{2{x[63]}}, x};
    endfunction

    // Saturate a signed 66-bit value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [65:0] x);
        logic [31:0] r;
        if (!x[65] && (x[64:31] != '0)) begin
            r = 32'h7FFF_FFFF;
        end else if (x[65] && (x[64:31] != '1)) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Tick program: one step per address.
    function automatic t_uop uop_decode(input logic [5:0] pc);
        t_uop u;
        u = '{op: OP_END, a: SRC_P, b: SRC_P, dst: DST_NONE, idx: 2'd0};
        unique case (pc) inside
            PC_RESPAWN: u.op = OP_RESPAWN;
            PC_CLIP:    u.op = OP_CLIP;
            [PC_GG:PC_GG+6'd2]: begin
                u.op = OP_MDOT; u.a = SRC_G; u.b = SRC_G; u.idx = 2'(pc - PC_GG);
            end
            PC_KNUM:    u.op = OP_NUMNEG;
            [PC_NG:PC_NG+6'd2]: begin
                u.op = OP_MDOT; u.a = SRC_N; u.b = SRC_G; u.idx = 2'(pc - PC_NG);
            end
            PC_KDEN:    u.op = OP_DEN;
            PC_KDIV: begin
                u.op = OP_DIV; u.dst = DST_K;
            end
            [PC_NK:PC_NK+6'd2]: begin
                u.op = OP_MADDM; u.a = SRC_N; u.b = SRC_K; u.dst = DST_ACC;
                u.idx = 2'(pc - PC_NK);
            end
            [PC_NV:PC_NV+6'd2]: begin
                u.op = OP_MDOT; u.a = SRC_N; u.b = SRC_V; u.idx = 2'(pc - PC_NV);
            end
            PC_HNUM:    u.op = OP_NUM;
            [PC_NN:PC_NN+6'd2]: begin
                u.op = OP_MDOT; u.a = SRC_N; u.b = SRC_N; u.idx = 2'(pc - PC_NN);
            end
            PC_HSQ:     u.op = OP_SQRT;
            PC_HDIV: begin
                u.op = OP_DIV; u.dst = DST_H;
            end
            [PC_NH:PC_NH+6'd2]: begin
                u.op = OP_MSUBM; u.a = SRC_N; u.b = SRC_H; u.dst = DST_V;
                u.idx = 2'(pc - PC_NH);
            end
            [PC_VV:PC_VV+6'd2]: begin
                u.op = OP_MDOT; u.a = SRC_V; u.b = SRC_V; u.idx = 2'(pc - PC_VV);
            end
            PC_VSQ:     u.op = OP_SQRT;
            PC_SLOW:    u.op = OP_SKIPSLOW;
            PC_FK: begin
                u.op = OP_MNEGNUM; u.a = SRC_FRIC; u.b = SRC_K;
            end
            PC_CDIV: begin
                u.op = OP_DIV; u.dst = DST_C;
            end
            [PC_VC:PC_VC+6'd2]: begin
                u.op = OP_MADDM; u.a = SRC_V; u.b = SRC_C; u.dst = DST_ACC;
                u.idx = 2'(pc - PC_VC);
            end
            [PC_INTEG:PC_INTEG+6'd2]: begin
                u.op = OP_MADDS; u.a = SRC_F; u.b = SRC_INVM; u.dst = DST_ACC;
                u.idx = 2'(pc - PC_INTEG);
            end
            [PC_VEL:PC_VEL+6'd2]: begin
                u.op = OP_MADDM; u.a = SRC_ACC; u.b = SRC_DT; u.dst = DST_V;
                u.idx = 2'(pc - PC_VEL);
            end
            [PC_POS:PC_POS+6'd2]: begin
                u.op = OP_MADDM; u.a = SRC_V; u.b = SRC_DT; u.dst = DST_P;
                u.idx = 2'(pc - PC_POS);
            end
            default: u.op = OP_END;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bbps_front.sv =====
// Front end: unpacks incoming requests, classifies them and holds them in a
// two-entry queue for the back end. Depends on bbps_pkg.
`default_nettype none

module bbps_front
    import bbps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tuser,
    output logic                      o_q_valid,
    output t_item                     o_q_item,
    input  wire logic                 i_q_pop
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    t_item       w_item;
    logic        w_push;

    // Unpack the stream word into item fields.
    always_comb begin
        w_item.is_tick   = s_axis_tuser;
        w_item.force_v[0] = s_axis_tdata[31:0];
        w_item.force_v[1] = s_axis_tdata[63:32];
        w_item.force_v[2] = s_axis_tdata[95:64];
        w_item.hit       = s_axis_tdata[96];
        w_item.clip[0]   = s_axis_tdata[128:97];
        w_item.clip[1]   = s_axis_tdata[160:129];
        w_item.clip[2]   = s_axis_tdata[192:161];
        w_item.normal[0] = s_axis_tdata[224:193];
        w_item.normal[1] = s_axis_tdata[256:225];
        w_item.normal[2] = s_axis_tdata[288:257];
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_count != 2'd0);
    assign o_q_item      = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bbps_div.sv =====
// Iterative fixed-point divider, one quotient bit per cycle, with
// saturation on overflow and on a zero divisor. Depends on bbps_pkg.
`default_nettype none

module bbps_div
    import bbps_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    localparam int DW = 95;

    logic [63:0]   w_un;
    logic [63:0]   w_ud;
    logic [63:0]   w_n;
    logic          w_neg;
    logic          w_ovf;
    logic [63:0]   r_rem;
    logic [DW-1:0] r_dsh;
    logic [30:0]   r_q;
    logic [4:0]    r_cnt;
    logic          r_neg;
    logic          r_busy;
    logic          w_ge;
    logic [30:0]   n_q;

    // Operand magnitudes and the overflow test against 2^31.
    always_comb begin
        w_neg = i_num[63] ^ i_den[63];
        w_un  = i_num[63] ? (64'd0 - i_num) : i_num;
        w_ud  = i_den[63] ? (64'd0 - i_den) : i_den;
        w_n   = w_un << FRAC_BITS;
        w_ovf = ({31'd0, w_n} >= {w_ud, 31'd0});
        w_ge  = ({31'd0, r_rem} >= r_dsh);
        n_q   = {r_q[29:0], w_ge};
    end

    // Restoring division over 31 quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                if (i_num == 64'd0) begin
                    o_quot <= 32'd0;
                    o_done <= 1'b1;
                end else if (i_den == 64'd0) begin
                    o_quot <= i_num[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    o_done <= 1'b1;
                end else if (w_ovf) begin
                    o_quot <= w_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    o_done <= 1'b1;
                end else begin
                    r_rem  <= w_n;
                    r_dsh  <= DW'(w_ud) << 30;
                    r_q    <= 31'd0;
                    r_cnt  <= 5'd30;
                    r_neg  <= w_neg;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[63:0];
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= n_q;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_quot <= r_neg ? (32'd0 - {1'b0, n_q}) : {1'b0, n_q};
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bbps_sqrt.sv =====
// Iterative integer square root of a 64-bit word, one result bit per cycle.
// Depends on bbps_pkg.
`default_nettype none

module bbps_sqrt
    import bbps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic [63:0] r_x;
    logic [33:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [35:0] w_rem;
    logic [35:0] w_trial;
    logic        w_ge;

    // Bring down the next bit pair and try the next root bit.
    always_comb begin
        w_rem   = {r_rem, r_x[63:62]};
        w_trial = {2'b00, o_root, 2'b01};
        w_ge    = (w_rem >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_rem  <= 34'd0;
                o_root <= 32'd0;
                r_cnt  <= 5'd31;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? 34'(w_rem - w_trial) : w_rem[33:0];
                o_root <= {o_root[30:0], w_ge};
                r_x    <= r_x << 2;
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bbps_core.sv =====
// Back end: body state and a sequencer that runs the tick program on one
// shared multiplier, divider and square-root unit. Depends on bbps_pkg,
// bbps_div and bbps_sqrt.
`default_nettype none

module bbps_core
    import bbps_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_q_valid,
    input  wire t_item                 i_q_item,
    output logic                       o_q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int          ONE     = 2 ** FRAC_BITS;
    localparam logic [31:0] FRIC    = 32'((8 * ONE + 50) / 100);
    localparam logic [63:0] SLOW    = 64'((ONE + 50) / 100);
    localparam logic [31:0] SPAWN_X = 32'(-7 * ONE);
    localparam logic [31:0] SPAWN_Y = 32'(8 * ONE);
    localparam logic [31:0] SPAWN_Z = 32'(-8 * ONE);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RUN  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state           r_state;
    logic [5:0]       r_pc;
    t_item            r_item;
    logic [2:0][31:0] r_p;
    logic [2:0][31:0] r_v;
    logic [2:0][31:0] r_f;
    logic [2:0][31:0] r_acc;
    logic [2:0][31:0] r_n;
    logic [31:0]      r_k;
    logic [31:0]      r_h;
    logic [31:0]      r_c;
    logic [63:0]      r_num;
    logic [63:0]      r_den;
    logic [63:0]      r_dot;
    logic [63:0]      r_prod;
    logic             r_gnd;

    t_uop             w_u;
    logic [31:0]      w_a;
    logic [31:0]      w_b;
    logic [63:0]      w_s;
    logic [31:0]      w_m;
    logic [31:0]      w_dcur;
    logic [31:0]      n_dst;
    logic             w_div_start;
    logic             w_sqrt_start;
    logic             w_div_done;
    logic             w_sqrt_done;
    logic [31:0]      w_quot;
    logic [31:0]      w_root;

    assign w_u = uop_decode(r_pc);

    // Multiplier operand selection.
    function automatic logic [31:0] pick(input t_src sel, input logic [1:0] idx,
                                         input logic [2:0][31:0] p,
                                         input logic [2:0][31:0] v,
                                         input logic [2:0][31:0] f,
                                         input logic [2:0][31:0] acc,
                                         input logic [2:0][31:0] n,
                                         input t_cfg cfg,
                                         input logic [31:0] k,
                                         input logic [31:0] h,
                                         input logic [31:0] c);
        logic [31:0] r;
        case (sel)
            SRC_P:    r = p[idx];
            SRC_V:    r = v[idx];
            SRC_F:    r = f[idx];
            SRC_ACC:  r = acc[idx];
            SRC_N:    r = n[idx];
            SRC_G:    r = cfg.gravity[idx];
            SRC_K:    r = k;
            SRC_H:    r = h;
            SRC_C:    r = c;
            SRC_FRIC: r = FRIC;
            SRC_INVM: r = {1'b0, cfg.inv_mass};
            SRC_DT:   r = {15'd0, cfg.dt};
            default:  r = 32'd0;
        endcase
        return r;
    endfunction

    assign w_a = pick(w_u.a, w_u.idx, r_p, r_v, r_f, r_acc, r_n, i_cfg, r_k, r_h, r_c);
    assign w_b = pick(w_u.b, w_u.idx, r_p, r_v, r_f, r_acc, r_n, i_cfg, r_k, r_h, r_c);

    // Post-processing of the registered product.
    always_comb begin
        w_s = 64'($signed(r_prod) >>> FRAC_BITS);
        w_m = sat32(sx64(w_s));
        case (w_u.dst)
            DST_ACC: w_dcur = r_acc[w_u.idx];
            DST_V:   w_dcur = r_v[w_u.idx];
            DST_P:   w_dcur = r_p[w_u.idx];
            default: w_dcur = 32'd0;
        endcase
        case (w_u.op)
            OP_MADDM: n_dst = sat32(sx32(w_dcur) + sx32(w_m));
            OP_MSUBM: n_dst = sat32(sx32(w_dcur) - sx32(w_m));
            OP_MADDS: n_dst = sat32(sx32(w_dcur) + sx64(w_s));
            default:  n_dst = w_dcur;
        endcase
    end

    assign w_div_start  = (r_state == ST_RUN) && (w_u.op == OP_DIV);
    assign w_sqrt_start = (r_state == ST_RUN) && (w_u.op == OP_SQRT);
    assign o_q_pop      = (r_state == ST_IDLE) && i_q_valid;

    bbps_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    bbps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_x     (r_dot << FRAC_BITS),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Sequencer and body state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pc          <= PC_RESPAWN;
            r_p           <= {SPAWN_Z, SPAWN_Y, SPAWN_X};
            r_v           <= '0;
            r_f           <= '0;
            r_gnd         <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        r_pc   <= PC_RESPAWN;
                        if (i_q_item.is_tick) begin
                            r_state <= ST_RUN;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_f[i] <= sat32(sx32(r_f[i]) + sx32(i_q_item.force_v[i]));
                            end
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_RUN: begin
                    r_pc <= r_pc + 6'd1;
                    case (w_u.op)
                        OP_RESPAWN: begin
                            if (r_p[1][31]) begin
                                r_p <= i_cfg.spawn;
                                r_v <= '0;
                                r_f <= '0;
                            end
                            r_acc <= i_cfg.gravity;
                            r_dot <= 64'd0;
                            if (!r_item.hit) begin
                                r_pc <= PC_INTEG;
                            end
                        end
                        OP_CLIP: begin
                            for (int i = 0; i < 3; i++) begin
                                r_p[i] <= sat32(sx32(r_p[i]) + sx32(r_item.clip[i]));
                            end
                            r_n <= r_item.normal;
                        end
                        OP_MDOT, OP_MADDM, OP_MSUBM, OP_MADDS, OP_MNEGNUM: begin
                            r_prod  <= 64'($signed(w_a) * $signed(w_b));
                            r_pc    <= r_pc;
                            r_state <= ST_MUL;
                        end
                        OP_NUMNEG: begin
                            r_num <= 64'd0 - r_dot;
                            r_dot <= 64'd0;
                        end
                        OP_NUM: begin
                            r_num <= r_dot;
                            r_dot <= 64'd0;
                        end
                        OP_DEN: begin
                            r_den <= r_dot;
                            r_dot <= 64'd0;
                        end
                        OP_SQRT, OP_DIV: begin
                            r_pc    <= r_pc;
                            r_state <= ST_WAIT;
                        end
                        OP_SKIPSLOW: begin
                            if (!($signed(r_den) > $signed(SLOW))) begin
                                r_pc <= PC_INTEG;
                            end
                        end
                        default: begin
                            r_f     <= '0;
                            r_gnd   <= r_item.hit;
                            r_pc    <= r_pc;
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_MUL: begin
                    case (w_u.op)
                        OP_MDOT:    r_dot <= r_dot + w_s;
                        OP_MNEGNUM: r_num <= 64'd0 - {{32{w_m[31]}}, w_m};
                        default: begin
                            case (w_u.dst)
                                DST_ACC: r_acc[w_u.idx] <= n_dst;
                                DST_V:   r_v[w_u.idx]   <= n_dst;
                                default: r_p[w_u.idx]   <= n_dst;
                            endcase
                        end
                    endcase
                    r_pc    <= r_pc + 6'd1;
                    r_state <= ST_RUN;
                end
                ST_WAIT: begin
                    if (w_sqrt_done) begin
                        r_den   <= {32'd0, w_root};
                        r_dot   <= 64'd0;
                        r_pc    <= r_pc + 6'd1;
                        r_state <= ST_RUN;
                    end else if (w_div_done) begin
                        case (w_u.dst)
                            DST_K:   r_k <= w_quot;
                            DST_H:   r_h <= w_quot;
                            default: r_c <= w_quot;
                        endcase
                        r_pc    <= r_pc + 6'd1;
                        r_state <= ST_RUN;
                    end
                end
                ST_DONE: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result register: loaded when a finished request is handed over.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
            m_axis_tdata <= {7'd0, r_gnd, r_v[2], r_v[1], r_v[0],
                             r_p[2], r_p[1], r_p[0]};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ball_body_physics_step.sv =====
// Top level of the ball body physics step: configuration registers and the
// front-end queue feeding the back-end sequencer. Depends on bbps_pkg,
// bbps_front and bbps_core.
//
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid/tready/tdata/tuser       one request (force or tick)
// m_axis    out  tvalid/tready/tdata             state after the request
// cfg       in   i_cfg_valid/o_cfg_ready/index/data  register write
//
// A force request only adds its force to the body; a tick without ground
// contact runs the respawn check and the integration steps. A tick with
// contact also runs the contact steps on the single shared multiplier, with
// three divisions and two square roots; slow bodies skip the friction steps
// and a saturating division ends without iterating. Reset is synchronous and
// active low and restores the register reset values and the body at the
// spawn point. The two-entry input queue keeps accepting, until it is full,
// while the back end works or the result waits.
`default_nettype none

module ball_body_physics_step
    import bbps_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tuser: command
    // tdata: force_x, force_y, force_z, ground_hit, clip_x, clip_y, clip_z,
    //        normal_x, normal_y, normal_z, zero pad
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    // tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, on_ground, zero pad
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);

    localparam int          ONE      = 2 ** FRAC_BITS;
    localparam logic [31:0] GRAV_Y   = 32'(-10 * ONE);
    localparam logic [30:0] INVM_RST = 31'(ONE);
    localparam logic [31:0] SPAWN_X  = 32'(-7 * ONE);
    localparam logic [31:0] SPAWN_Y  = 32'(8 * ONE);
    localparam logic [31:0] SPAWN_Z  = 32'(-8 * ONE);
    localparam logic [16:0] DT_RST   = 17'((ONE + 30) / 60);

    t_cfg  r_cfg;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity  <= {32'd0, GRAV_Y, 32'd0};
            r_cfg.inv_mass <= INVM_RST;
            r_cfg.spawn    <= {SPAWN_Z, SPAWN_Y, SPAWN_X};
            r_cfg.dt       <= DT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRAVITY_X: r_cfg.gravity[0] <= i_cfg_data;
                CFG_GRAVITY_Y: r_cfg.gravity[1] <= i_cfg_data;
                CFG_GRAVITY_Z: r_cfg.gravity[2] <= i_cfg_data;
                CFG_INV_MASS:  r_cfg.inv_mass   <= i_cfg_data[30:0];
                CFG_SPAWN_X:   r_cfg.spawn[0]   <= i_cfg_data;
                CFG_SPAWN_Y:   r_cfg.spawn[1]   <= i_cfg_data;
                CFG_SPAWN_Z:   r_cfg.spawn[2]   <= i_cfg_data;
                CFG_TIME_STEP: r_cfg.dt         <= i_cfg_data[16:0];
                default:       r_cfg.dt         <= r_cfg.dt;
            endcase
        end
    end

    bbps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    bbps_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/ball_body_physics_step_test.sv =====
// Self-checking testbench for the ball body physics step: drives force and tick
// requests and register writes, and checks every result against a predictor.
// Depends on bbps_pkg and the ball_body_physics_step RTL.
`timescale 1ns / 100ps

module ball_body_physics_step_test;
    import bbps_pkg::*;

    localparam longint CYCLE_LIMIT = 1000000;
    localparam int FRIC_K = 5243;   // 0.08 in Q16.16
    localparam int SLOW_V = 655;    // 0.01 in Q16.16
    localparam int INT_MAX = 32'sh7FFF_FFFF;
    localparam int INT_MIN = 32'sh8000_0000;

    typedef int vec3_t[3];

    // One request as the sender sees it.
    typedef struct {
        bit    tick;
        int    force_v[3];
        bit    hit;
        int    clip[3];
        int    normal[3];
    } body_req_t;

    typedef logic [6:0][31:0] body_state_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [2:0]            i_cfg_index = '0;
    logic [31:0]           i_cfg_data = '0;

    ball_body_physics_step i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers and the body.
    int      cfg_gravity[3];
    int      cfg_spawn[3];
    longint  cfg_inv_mass;
    longint  cfg_dt;
    int      body_pos[3];
    int      body_vel[3];
    int      body_force[3];
    bit      body_grounded;

    body_state_t expected_states[$];
    int          mismatches = 0;
    longint      cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_rx = 1'b0;
    bit          rx_taken = 1'b0;

    // Fixed-point helpers.
    function automatic int sat_w(input longint x);
        if (x > longint'(INT_MAX)) return INT_MAX;
        if (x < longint'(INT_MIN)) return INT_MIN;
        return int'(x);
    endfunction

    function automatic int add_w(input int a, input int b);
        return sat_w(longint'(a) + longint'(b));
    endfunction

    function automatic int q_mul(input int a, input int b);
        return sat_w((longint'(a) * longint'(b)) >>> 16);
    endfunction

    function automatic longint q_dot(input vec3_t a, input vec3_t b);
        longint s;
        s = 0;
        for (int i = 0; i < 3; i++) s += (longint'(a[i]) * longint'(b[i])) >>> 16;
        return s;
    endfunction

    function automatic int q_div(input longint num, input longint den);
        longint unsigned un, ud, ip, rm, q;
        bit neg;
        neg = (num < 0) != (den < 0);
        if (num == 0) return 0;
        if (den == 0) return (num > 0) ? INT_MAX : INT_MIN;
        un = (num < 0) ? longint'(-num) : num;
        ud = (den < 0) ? longint'(-den) : den;
        ip = un / ud;
        rm = un % ud;
        if ((ip >> 15) != 0) return neg ? INT_MIN : INT_MAX;
        q = (ip << 16) + ((rm << 16) / ud);
        return neg ? -int'(q) : int'(q);
    endfunction

    function automatic longint q_len(input vec3_t a);
        longint unsigned x, r, b;
        x = longint'(q_dot(a, a)) << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic model_reset();
        cfg_gravity = '{0, -655360, 0};
        cfg_spawn = '{-458752, 524288, -524288};
        cfg_inv_mass = 65536;
        cfg_dt = 1092;
        body_pos = cfg_spawn;
        body_vel = '{0, 0, 0};
        body_force = '{0, 0, 0};
        body_grounded = 1'b0;
    endtask

    // Advance the body by one request and return the state it leaves.
    function automatic body_state_t advance_body(input body_req_t r);
        int acc[3];
        int n[3];
        int k, h, c;
        longint len;
        body_state_t s;
        if (!r.tick) begin
            for (int i = 0; i < 3; i++) body_force[i] = add_w(body_force[i], r.force_v[i]);
        end else begin
            if (body_pos[1] < 0) begin
                body_pos = cfg_spawn;
                body_vel = '{0, 0, 0};
                body_force = '{0, 0, 0};
            end
            acc = cfg_gravity;
            if (r.hit) begin
                for (int i = 0; i < 3; i++) body_pos[i] = add_w(body_pos[i], r.clip[i]);
                n = r.normal;
                k = q_div(-q_dot(cfg_gravity, cfg_gravity), q_dot(n, cfg_gravity));
                for (int i = 0; i < 3; i++) acc[i] = add_w(acc[i], q_mul(n[i], k));
                h = q_div(q_dot(n, body_vel), q_len(n));
                for (int i = 0; i < 3; i++)
                    body_vel[i] = sat_w(longint'(body_vel[i]) - longint'(q_mul(n[i], h)));
                len = q_len(body_vel);
                if (len > SLOW_V) begin
                    c = q_div(-longint'(q_mul(FRIC_K, k)), len);
                    for (int i = 0; i < 3; i++) acc[i] = add_w(acc[i], q_mul(body_vel[i], c));
                end
            end
            for (int i = 0; i < 3; i++) begin
                acc[i] = sat_w(longint'(acc[i])
                               + ((longint'(body_force[i]) * cfg_inv_mass) >>> 16));
                body_vel[i] = add_w(body_vel[i],
                                    sat_w((longint'(acc[i]) * cfg_dt) >>> 16));
                body_pos[i] = add_w(body_pos[i],
                                    sat_w((longint'(body_vel[i]) * cfg_dt) >>> 16));
                body_force[i] = 0;
            end
            body_grounded = r.hit;
        end
        for (int i = 0; i < 3; i++) begin
            s[i] = body_pos[i];
            s[3 + i] = body_vel[i];
        end
        s[6] = {31'b0, body_grounded};
        return s;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
    endtask

    // Send one request, waiting a random gap first.
    task automatic send_request(input body_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.tick;
        s_axis_tdata <= {7'b0, r.normal[2], r.normal[1], r.normal[0],
                         r.clip[2], r.clip[1], r.clip[0], r.hit,
                         r.force_v[2], r.force_v[1], r.force_v[0]};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        expected_states.push_back(advance_body(r));
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (expected_states.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    // Register write; only called once the block has drained.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_GRAVITY_X: cfg_gravity[0] = data;
            CFG_GRAVITY_Y: cfg_gravity[1] = data;
            CFG_GRAVITY_Z: cfg_gravity[2] = data;
            CFG_INV_MASS:  cfg_inv_mass = data & 32'h7FFF_FFFF;
            CFG_SPAWN_X:   cfg_spawn[0] = data;
            CFG_SPAWN_Y:   cfg_spawn[1] = data;
            CFG_SPAWN_Z:   cfg_spawn[2] = data;
            CFG_TIME_STEP: cfg_dt = data & 32'h0001_FFFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input int gx, input int gy, input int gz, input logic [31:0] im,
                           input int sx, input int sy, input int sz, input logic [31:0] dt);
        drain();
        write_reg(CFG_GRAVITY_X, gx);
        write_reg(CFG_GRAVITY_Y, gy);
        write_reg(CFG_GRAVITY_Z, gz);
        write_reg(CFG_INV_MASS, im);
        write_reg(CFG_SPAWN_X, sx);
        write_reg(CFG_SPAWN_Y, sy);
        write_reg(CFG_SPAWN_Z, sz);
        write_reg(CFG_TIME_STEP, dt);
    endtask

    function automatic int small_val(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random request, mostly with plausible forces, clips and normals, with some raw noise.
    function automatic body_req_t random_request();
        body_req_t r;
        int pick;
        r.tick = ($urandom_range(0, 9) >= 4);
        r.hit = $urandom_range(0, 1);
        pick = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            r.force_v[i] = (pick < 8) ? small_val(1 << 20) : int'($urandom);
            r.clip[i] = (pick < 8) ? small_val(1 << 15) : int'($urandom);
            r.normal[i] = int'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            r.normal[0] = small_val(20000);
            r.normal[1] = $urandom_range(40000, 70000);
            r.normal[2] = small_val(20000);
        end else if (pick == 7) begin
            r.normal = '{0, 0, 0};
        end
        return r;
    endfunction

    function automatic body_req_t make_req(input bit tick, input bit hit, input vec3_t f,
                                           input vec3_t cl, input vec3_t nm);
        body_req_t r;
        r.tick = tick;
        r.hit = hit;
        r.force_v = f;
        r.clip = cl;
        r.normal = nm;
        return r;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        body_state_t want;
        body_state_t got;
        if (m_axis_tvalid && m_axis_tready) begin
            rx_taken = 1'b1;
            for (int i = 0; i < 6; i++) got[i] = m_axis_tdata[32 * i +: 32];
            got[6] = {31'b0, m_axis_tdata[192]};
            if (expected_states.size() == 0) begin
                report("unexpected result", got[0], 32'b0);
            end else begin
                want = expected_states.pop_front();
                for (int i = 0; i < 7; i++)
                    if (got[i] !== want[i])
                        report($sformatf("field %0d", i), got[i], want[i]);
            end
        end
    end

    // Receiver: random stalls per result, plus the long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_taken) begin
                rx_taken = 1'b0;
                stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (hold_rx || stall > 0) begin
                m_axis_tready <= 1'b0;
                if (!hold_rx) stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here.
    initial begin
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            hold_rx = 1'b1;
            repeat (400) @(posedge i_clk);
            hold_rx = 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(make_req(0, 0, '{INT_MAX, INT_MIN, 1}, '{0, 0, 0}, '{0, 0, 0}));
        send_request(make_req(0, 0, '{INT_MAX, INT_MIN, -1}, '{0, 0, 0}, '{0, 0, 0}));
        send_request(make_req(1, 0, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{0, 1000, 0}, '{0, 65536, 0}));
        send_request(make_req(0, 0, '{65536, 0, -65536}, '{0, 0, 0}, '{0, 0, 0}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
        // Normal at right angles to gravity: division by zero.
        send_request(make_req(1, 1, '{0, 0, 0}, '{10, 0, 0}, '{65536, 0, 0}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{INT_MAX, INT_MAX, INT_MAX},
                              '{INT_MIN, INT_MIN, INT_MIN}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{INT_MIN, INT_MIN, INT_MIN},
                              '{INT_MAX, INT_MAX, INT_MAX}));
        // Below the floor: the next tick respawns.
        send_request(make_req(0, 0, '{INT_MAX, INT_MAX, INT_MAX}, '{0, 0, 0}, '{0, 0, 0}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{0, INT_MIN, 0}, '{0, 65536, 0}));
        send_request(make_req(1, 0, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{0, 0, 0}, '{3000, 60000, -3000}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{0, 0, 0}, '{-1, -1, -1}));
        send_request(make_req(1, 1, '{0, 0, 0}, '{-1, -1, -1}, '{1, 1, 1}));
    endtask

    task automatic test_register_extremes();
        set_all(INT_MAX, INT_MAX, INT_MAX, 32'hFFFF_FFFF, INT_MAX, INT_MAX, INT_MAX,
                32'hFFFF_0000 | 32'd65536);
        repeat (30) send_request(random_request());
        set_all(INT_MIN, INT_MIN, INT_MIN, 0, INT_MIN, INT_MIN, INT_MIN, 1);
        repeat (30) send_request(random_request());
        set_all(0, 0, 0, 1, 0, -1, 0, 32'hFFFE_0001);
        repeat (30) send_request(random_request());
        set_all(1000, -1000000, -500, 32'h8000_0000 | 32'd131072, 65536, 0, -65536, 4369);
        repeat (30) send_request(random_request());
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        hold_req = 1'b1;
        repeat (20) send_request(random_request());
    endtask

    task automatic test_random();
        set_all(0, -655360, 0, 65536, -458752, 524288, -524288, 1092);
        no_idle = 1'b1;
        repeat (100) send_request(random_request());
        no_idle = 1'b0;
        repeat (400) send_request(random_request());
        set_all(small_val(1 << 18), -int'($urandom_range(1, 1 << 21)), small_val(1 << 18),
                $urandom_range(0, 1 << 18), small_val(1 << 20), $urandom_range(0, 1 << 22),
                small_val(1 << 20), $urandom_range(1, 65536));
        repeat (500) send_request(random_request());
    endtask

    initial begin
        model_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random();
        drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
